/* sv/swf_pkg.sv */
// Shared constants, types and colour helper for the waterfall line store.
package swf_pkg;

  localparam int MAX_WIDTH = 512;
  localparam int MAX_LINES = 128;
  localparam int LEVELS    = 232;
  localparam int MAX_ZOOM  = 16;

  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int LINE_BITS  = $clog2(MAX_LINES);
  localparam int ADDR_BITS  = COL_BITS + LINE_BITS;
  localparam int DEPTH      = MAX_WIDTH * MAX_LINES;
  localparam int WIDTH_BITS = $clog2(MAX_WIDTH + 1);
  localparam int CNT_BITS   = $clog2(MAX_LINES + 1);
  localparam int SUM_BITS   = CNT_BITS + 1;

  localparam int SAMPLE_BITS = 16;
  localparam int DIFF_BITS   = SAMPLE_BITS + 1;
  localparam int LEVEL_BITS  = 8;
  localparam int PROD_BITS   = SAMPLE_BITS + LEVEL_BITS;
  localparam int STEP_BITS   = $clog2(LEVEL_BITS);

  localparam int LW_BITS   = 10;
  localparam int LC_BITS   = 8;
  localparam int ZOOM_BITS = 5;
  localparam int AGE_BITS  = 7;
  localparam int COLF_BITS = 9;
  localparam int PHASE_BITS = 4;
  localparam int IDX_BITS  = 3;
  localparam int DATA_BITS = 16;
  localparam int RGB_BITS  = 8;

  localparam int GREEN_BASE  = 7;
  localparam int BLUE_BASE   = 23;
  localparam int WHITE       = 255;
  localparam int RECIP_SHIFT = 15;
  localparam int RECIP_23    = (2 ** RECIP_SHIFT + BLUE_BASE - 1) / BLUE_BASE;
  localparam int GREEN_MUL   = GREEN_BASE * RECIP_23;
  localparam int GPROD_BITS  = 22;

  localparam logic [IDX_BITS-1:0] REG_LINE_WIDTH = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_LINE_COUNT = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_REF_LOW    = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_REF_HIGH   = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_ZOOM       = 3'd4;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [LW_BITS-1:0]          RST_LINE_WIDTH = 10'd512;
  localparam logic [LC_BITS-1:0]          RST_LINE_COUNT = 8'd128;
  localparam logic signed [DATA_BITS-1:0] RST_REF_LOW    = -16'sd1920;
  localparam logic signed [DATA_BITS-1:0] RST_REF_HIGH   = -16'sd640;
  localparam logic [ZOOM_BITS-1:0]        RST_ZOOM       = 5'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // 7 + lv*7/23 by reciprocal, exact for lv below LEVELS
  function automatic logic [RGB_BITS-1:0] green_of(input logic [LEVEL_BITS-1:0] lv);
    logic [GPROD_BITS-1:0] p;
    begin
      p = GPROD_BITS'(lv) * GPROD_BITS'(GREEN_MUL);
      green_of = RGB_BITS'(GREEN_BASE) + RGB_BITS'(p >> RECIP_SHIFT);
    end
  endfunction

endpackage

/* sv/swf_if.sv */
// Handshake channels: sample/read items, colour results and register writes.
interface swf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   opcode;
  logic signed [swf_pkg::SAMPLE_BITS-1:0] sample;
  logic [swf_pkg::AGE_BITS-1:0]           age;
  logic [swf_pkg::COLF_BITS-1:0]          column;
  modport source (output valid, opcode, sample, age, column, input ready);
  modport sink (input valid, opcode, sample, age, column, output ready);
endinterface

interface swf_out_if;
  logic                         valid;
  logic                         ready;
  logic [swf_pkg::RGB_BITS-1:0] red;
  logic [swf_pkg::RGB_BITS-1:0] green;
  logic [swf_pkg::RGB_BITS-1:0] blue;
  logic                         valid_res;
  modport source (output valid, red, green, blue, valid_res, input ready);
  modport sink (input valid, red, green, blue, valid_res, output ready);
endinterface

interface swf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [swf_pkg::IDX_BITS-1:0]  index;
  logic [swf_pkg::DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/swf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module swf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/swf_div.sv */
// Restoring divider, one quotient bit per cycle, quotient known to fit LEVEL_BITS.
module swf_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [swf_pkg::PROD_BITS-1:0]     dividend,
  input  logic [swf_pkg::SAMPLE_BITS-1:0]   divisor,
  output logic [swf_pkg::LEVEL_BITS-1:0]    quot,
  output swf_pkg::div_stat_t                stat
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [swf_pkg::STEP_BITS-1:0]   cnt_r, cnt_nxt;
  logic [swf_pkg::SAMPLE_BITS-1:0] rem_r, rem_nxt;
  logic [swf_pkg::SAMPLE_BITS-1:0] dvs_r, dvs_nxt;
  logic [swf_pkg::LEVEL_BITS-1:0]  low_r, low_nxt;
  logic [swf_pkg::LEVEL_BITS-1:0]  quot_r, quot_nxt;
  logic [swf_pkg::DIFF_BITS-1:0]   trial;
  logic                            take;

  assign trial = {rem_r, low_r[swf_pkg::LEVEL_BITS-1]};
  assign take  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    low_nxt  = low_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = dividend[swf_pkg::PROD_BITS-1:swf_pkg::LEVEL_BITS];
      low_nxt  = dividend[swf_pkg::LEVEL_BITS-1:0];
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = take ? swf_pkg::SAMPLE_BITS'(trial - {1'b0, dvs_r})
                      : swf_pkg::SAMPLE_BITS'(trial);
      low_nxt  = {low_r[swf_pkg::LEVEL_BITS-2:0], 1'b0};
      quot_nxt = {quot_r[swf_pkg::LEVEL_BITS-2:0], take};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == swf_pkg::STEP_BITS'(swf_pkg::LEVEL_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    low_r  <= low_nxt;
    quot_r <= quot_nxt;
  end

  assign quot      = quot_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* sv/spectrum_waterfall_line_store.sv */
// Waterfall line store top level: bookkeeping, level sequencer, pixel readout.
// One item at a time. A sample of a dropped line stays in the idle state; a
// kept sample runs through the prepare, multiply and write states when its level
// is settled by compares (empty span, at or below the low reference, at or above
// the high reference), else also through the divide state for the 8 steps of the
// bit-serial divider and its done flag. A read waits in the read state for the
// registered port of the level memory (skipped outside the written area), then
// in the output state for the output register to empty; level memory is not cleared.
module spectrum_waterfall_line_store (
  input  logic      clk,
  input  logic      rst_n,
  swf_in_if.sink    in_ch,
  swf_out_if.source out_ch,
  swf_cfg_if.sink   cfg_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // registers
  logic [swf_pkg::LW_BITS-1:0]          line_width_r;
  logic [swf_pkg::LC_BITS-1:0]          line_count_r;
  logic signed [swf_pkg::DATA_BITS-1:0] ref_low_r;
  logic signed [swf_pkg::DATA_BITS-1:0] ref_high_r;
  logic [swf_pkg::ZOOM_BITS-1:0]        zoom_r;

  logic [2:0]                           state_r, state_nxt;
  logic [swf_pkg::LINE_BITS-1:0]        write_line_r, write_line_nxt;
  logic [swf_pkg::COL_BITS-1:0]         column_position_r, column_position_nxt;
  logic [swf_pkg::PHASE_BITS-1:0]       line_phase_r, line_phase_nxt;
  logic                                 keep_r, keep_nxt;
  logic [swf_pkg::CNT_BITS-1:0]         lines_filled_r, lines_filled_nxt;

  logic signed [swf_pkg::SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic signed [swf_pkg::DIFF_BITS-1:0]   num_r, num_nxt;
  logic signed [swf_pkg::DIFF_BITS-1:0]   span_r, span_nxt;
  logic [swf_pkg::LEVEL_BITS-1:0]         level_r, level_nxt;
  logic [swf_pkg::ADDR_BITS-1:0]          wr_addr_r, wr_addr_nxt;
  logic [swf_pkg::ADDR_BITS-1:0]          rd_addr_r, rd_addr_nxt;
  logic                                   ok_r, ok_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [swf_pkg::RGB_BITS-1:0] red_r, red_nxt;
  logic [swf_pkg::RGB_BITS-1:0] green_r, green_nxt;
  logic [swf_pkg::RGB_BITS-1:0] blue_r, blue_nxt;
  logic                         vres_r, vres_nxt;

  // derived
  logic [swf_pkg::WIDTH_BITS-1:0] width_eff;
  logic [swf_pkg::CNT_BITS-1:0]   count_eff;
  logic [swf_pkg::ZOOM_BITS-1:0]  zoom_eff;
  logic [swf_pkg::LINE_BITS-1:0]  wl_eff;
  logic [swf_pkg::LINE_BITS-1:0]  wl_inc;
  logic [swf_pkg::COL_BITS-1:0]   col_cur;
  logic                           keep_now;
  logic [swf_pkg::CNT_BITS-1:0]   avail;
  logic                           rd_ok;
  logic [swf_pkg::SUM_BITS-1:0]   rd_sum;
  logic [swf_pkg::LINE_BITS-1:0]  rd_line;
  logic                           in_fire;
  logic                           out_free;

  logic                            div_start;
  logic [swf_pkg::PROD_BITS-1:0]   div_dividend;
  logic [swf_pkg::LEVEL_BITS-1:0]  div_quot;
  swf_pkg::div_stat_t              div_st;

  logic                            ram_we;
  logic [swf_pkg::LEVEL_BITS-1:0]  ram_rdata;

  assign in_fire  = in_ch.valid & in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    if (line_width_r == '0) begin
      width_eff = swf_pkg::WIDTH_BITS'(1);
    end else if (int'(line_width_r) > swf_pkg::MAX_WIDTH) begin
      width_eff = swf_pkg::WIDTH_BITS'(swf_pkg::MAX_WIDTH);
    end else begin
      width_eff = swf_pkg::WIDTH_BITS'(line_width_r);
    end
    if (line_count_r == '0) begin
      count_eff = swf_pkg::CNT_BITS'(1);
    end else if (int'(line_count_r) > swf_pkg::MAX_LINES) begin
      count_eff = swf_pkg::CNT_BITS'(swf_pkg::MAX_LINES);
    end else begin
      count_eff = swf_pkg::CNT_BITS'(line_count_r);
    end
    if (zoom_r == '0) begin
      zoom_eff = swf_pkg::ZOOM_BITS'(1);
    end else if (int'(zoom_r) > swf_pkg::MAX_ZOOM) begin
      zoom_eff = swf_pkg::ZOOM_BITS'(swf_pkg::MAX_ZOOM);
    end else begin
      zoom_eff = zoom_r;
    end
  end

  always_comb begin
    wl_eff   = (int'(write_line_r) >= int'(count_eff)) ? '0 : write_line_r;
    wl_inc   = (int'(wl_eff) + 1 == int'(count_eff)) ? '0 : wl_eff + 1'b1;
    col_cur  = (int'(column_position_r) >= int'(width_eff)) ? '0 : column_position_r;
    keep_now = (col_cur == '0) ? (int'(line_phase_r) + 1 >= int'(zoom_eff)) : keep_r;
    avail    = (lines_filled_r < count_eff) ? lines_filled_r : count_eff;
    rd_ok    = (int'(in_ch.age) < int'(avail)) && (int'(in_ch.column) < int'(width_eff));
    rd_sum   = swf_pkg::SUM_BITS'(wl_eff) + swf_pkg::SUM_BITS'(count_eff) - 1'b1
             - swf_pkg::SUM_BITS'(in_ch.age);
    rd_line  = (rd_sum >= swf_pkg::SUM_BITS'(count_eff))
             ? swf_pkg::LINE_BITS'(rd_sum - swf_pkg::SUM_BITS'(count_eff))
             : swf_pkg::LINE_BITS'(rd_sum);
  end

  assign div_dividend = swf_pkg::PROD_BITS'(num_r[swf_pkg::SAMPLE_BITS-1:0])
                      * swf_pkg::PROD_BITS'(swf_pkg::LEVELS);

  always_comb begin
    state_nxt           = state_r;
    write_line_nxt      = write_line_r;
    column_position_nxt = column_position_r;
    line_phase_nxt      = line_phase_r;
    keep_nxt            = keep_r;
    lines_filled_nxt    = lines_filled_r;
    sample_nxt          = sample_r;
    num_nxt             = num_r;
    span_nxt            = span_r;
    level_nxt           = level_r;
    wr_addr_nxt         = wr_addr_r;
    rd_addr_nxt         = rd_addr_r;
    ok_nxt              = ok_r;
    out_valid_nxt       = out_valid_r && !out_ch.ready;
    red_nxt             = red_r;
    green_nxt           = green_r;
    blue_nxt            = blue_r;
    vres_nxt            = vres_r;
    div_start           = 1'b0;
    ram_we              = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          write_line_nxt = wl_eff;
          if (in_ch.opcode == swf_pkg::OP_READ) begin
            rd_addr_nxt = {rd_line, swf_pkg::COL_BITS'(in_ch.column)};
            ok_nxt      = rd_ok;
            state_nxt   = rd_ok ? S_RD : S_OUT;
          end else begin
            sample_nxt  = in_ch.sample;
            wr_addr_nxt = {wl_eff, col_cur};
            keep_nxt    = keep_now;
            if (col_cur == '0) begin
              line_phase_nxt = keep_now ? '0 : line_phase_r + 1'b1;
            end
            if (int'(col_cur) + 1 >= int'(width_eff)) begin
              column_position_nxt = '0;
              if (keep_now) begin
                write_line_nxt = wl_inc;
                if (int'(lines_filled_r) < swf_pkg::MAX_LINES) begin
                  lines_filled_nxt = lines_filled_r + 1'b1;
                end
              end
            end else begin
              column_position_nxt = col_cur + 1'b1;
            end
            state_nxt = keep_now ? S_PREP : S_IDLE;
          end
        end
      end
      S_PREP: begin
        num_nxt   = swf_pkg::DIFF_BITS'(sample_r) - swf_pkg::DIFF_BITS'(ref_low_r);
        span_nxt  = swf_pkg::DIFF_BITS'(ref_high_r) - swf_pkg::DIFF_BITS'(ref_low_r);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        priority if (span_r <= 0) begin
          level_nxt = swf_pkg::LEVEL_BITS'(swf_pkg::LEVELS);
          state_nxt = S_WR;
        end else if (num_r <= 0) begin
          level_nxt = '0;
          state_nxt = S_WR;
        end else if (num_r >= span_r) begin
          level_nxt = swf_pkg::LEVEL_BITS'(swf_pkg::LEVELS);
          state_nxt = S_WR;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          level_nxt = div_quot;
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        ram_we    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          vres_nxt      = ok_r;
          if (!ok_r) begin
            red_nxt   = '0;
            green_nxt = '0;
            blue_nxt  = '0;
          end else if (int'(ram_rdata) >= swf_pkg::LEVELS) begin
            red_nxt   = swf_pkg::RGB_BITS'(swf_pkg::WHITE);
            green_nxt = swf_pkg::RGB_BITS'(swf_pkg::WHITE);
            blue_nxt  = swf_pkg::RGB_BITS'(swf_pkg::WHITE);
          end else begin
            red_nxt   = '0;
            green_nxt = swf_pkg::green_of(ram_rdata);
            blue_nxt  = swf_pkg::RGB_BITS'(swf_pkg::BLUE_BASE) + ram_rdata;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= swf_pkg::RST_LINE_WIDTH;
      line_count_r <= swf_pkg::RST_LINE_COUNT;
      ref_low_r    <= swf_pkg::RST_REF_LOW;
      ref_high_r   <= swf_pkg::RST_REF_HIGH;
      zoom_r       <= swf_pkg::RST_ZOOM;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        swf_pkg::REG_LINE_WIDTH: line_width_r <= cfg_ch.data[swf_pkg::LW_BITS-1:0];
        swf_pkg::REG_LINE_COUNT: line_count_r <= cfg_ch.data[swf_pkg::LC_BITS-1:0];
        swf_pkg::REG_REF_LOW:    ref_low_r    <= cfg_ch.data;
        swf_pkg::REG_REF_HIGH:   ref_high_r   <= cfg_ch.data;
        swf_pkg::REG_ZOOM:       zoom_r       <= cfg_ch.data[swf_pkg::ZOOM_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      write_line_r      <= '0;
      column_position_r <= '0;
      line_phase_r      <= '0;
      keep_r            <= 1'b0;
      lines_filled_r    <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      state_r           <= state_nxt;
      write_line_r      <= write_line_nxt;
      column_position_r <= column_position_nxt;
      line_phase_r      <= line_phase_nxt;
      keep_r            <= keep_nxt;
      lines_filled_r    <= lines_filled_nxt;
      out_valid_r       <= out_valid_nxt;
    end
    sample_r  <= sample_nxt;
    num_r     <= num_nxt;
    span_r    <= span_nxt;
    level_r   <= level_nxt;
    wr_addr_r <= wr_addr_nxt;
    rd_addr_r <= rd_addr_nxt;
    ok_r      <= ok_nxt;
    red_r     <= red_nxt;
    green_r   <= green_nxt;
    blue_r    <= blue_nxt;
    vres_r    <= vres_nxt;
  end

  swf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (span_r[swf_pkg::SAMPLE_BITS-1:0]),
    .quot     (div_quot),
    .stat     (div_st)
  );

  swf_ram #(
    .WIDTH (swf_pkg::LEVEL_BITS),
    .DEPTH (swf_pkg::DEPTH)
  ) u_levels (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr_r),
    .wdata (level_r),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  assign in_ch.ready      = (state_r == S_IDLE);
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.red       = red_r;
  assign out_ch.green     = green_r;
  assign out_ch.blue      = blue_r;
  assign out_ch.valid_res = vres_r;

`ifndef ASSERT_OFF
  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> state_r == S_DIV)
    else $error("divider running outside its state");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> int'(level_r) <= swf_pkg::LEVELS)
    else $error("level above white written");

  a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.opcode == swf_pkg::OP_READ) |=> (state_r == S_RD || state_r == S_OUT))
    else $error("read item left the read path");

  a_fill_sat: assert property (@(posedge clk) disable iff (!rst_n)
    int'(lines_filled_r) <= swf_pkg::MAX_LINES)
    else $error("line fill count past ring size");
`endif

endmodule
